// ----- src/sprn_pkg.sv -----
// ----------------------------------------------------------------------------
// sprn_pkg
// Shared types and constants for the nearest-neighbor sprite rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package sprn_pkg;

    // Geometry
    localparam int MAX_SIDE  = 64;
    localparam int POS_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = POS_W + 1;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Arithmetic widths
    localparam int TRIG_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int DELTA_W   = POS_W + 3;
    localparam int PROD_W    = TRIG_W + DELTA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COORD_W   = SUM_W - (FRAC_BITS + 1);

    // Pixels
    localparam int COLOR_W = 4;
    localparam logic [COLOR_W-1:0] COLOR_TRANSPARENT = 4'h8;

    // Result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Request kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Register indexes
    typedef enum logic [1:0] {
        REG_SINE   = 2'd0,
        REG_COSINE = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } sprn_reg_t;

    // Active configuration, sides already clamped to MAX_SIDE
    typedef struct packed {
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
        logic [SIDE_W-1:0]        width;
        logic [SIDE_W-1:0]        height;
    } sprn_cfg_t;

    // One request moving down the pipe
    typedef struct packed {
        logic               vld;
        logic               query;
        logic               in_sprite;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } sprn_item_t;

    // Request after inverse mapping
    typedef struct packed {
        sprn_item_t       item;
        logic             map_ok;
        logic [POS_W-1:0] rx;
        logic [POS_W-1:0] ry;
    } sprn_mapped_t;

    // Finished result
    typedef struct packed {
        logic               vld;
        logic [COLOR_W-1:0] color;
        logic               outside;
    } sprn_result_t;

endpackage

`default_nettype wire

// ----- src/sprn_cfg.sv -----
// ----------------------------------------------------------------------------
// sprn_cfg
// Configuration registers; clamps the sprite sides to the store size.
// ----------------------------------------------------------------------------
`default_nettype none

module sprn_cfg
    import sprn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [TRIG_W-1:0] cfg_data,
    output sprn_cfg_t              cfg
);

    logic [TRIG_W-1:0] sine_reg;
    logic [TRIG_W-1:0] cosine_reg;
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_reg   <= '0;
            cosine_reg <= TRIG_W'(1 << FRAC_BITS);
            width_reg  <= SIDE_W'(MAX_SIDE);
            height_reg <= SIDE_W'(MAX_SIDE);
        end
        else if (cfg_valid)
        begin
            case (sprn_reg_t'(cfg_index))
                REG_SINE:   sine_reg   <= cfg_data;
                REG_COSINE: cosine_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[SIDE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Clamp oversized sides
    always_comb
    begin
        cfg.sine   = $signed(sine_reg);
        cfg.cosine = $signed(cosine_reg);
        cfg.width  = (width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_reg;
        cfg.height = (height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_reg;
    end

endmodule

`default_nettype wire

// ----- src/sprn_map.sv -----
// ----------------------------------------------------------------------------
// sprn_map
// Input register, rotation products and inverse-mapped source coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module sprn_map
    import sprn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sprn_cfg_t              cfg,
    input  wire logic              in_accept,
    input  wire logic              in_query,
    input  wire logic [POS_W-1:0]  in_x,
    input  wire logic [POS_W-1:0]  in_y,
    input  wire logic [COLOR_W-1:0] in_color,
    output sprn_mapped_t           mapped
);

    sprn_item_t item_reg;
    sprn_item_t item_next;
    sprn_item_t prod_item_reg;

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [PROD_W-1:0]  cdx_next, sdy_next, sdx_next, cdy_next;
    logic signed [PROD_W-1:0]  cdx_reg, sdy_reg, sdx_reg, cdy_reg;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [COORD_W-1:0] rx_full, ry_full;
    logic                      rx_ok, ry_ok;
    sprn_mapped_t              mapped_next;
    sprn_mapped_t              mapped_reg;

    // Input register
    always_comb
    begin
        item_next.vld       = in_accept;
        item_next.query     = (in_query == ACT_QUERY);
        item_next.in_sprite = ({1'b0, in_x} < cfg.width) && ({1'b0, in_y} < cfg.height);
        item_next.x         = in_x;
        item_next.y         = in_y;
        item_next.color     = in_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    // Centered doubled offsets and the four products
    always_comb
    begin
        dx = $signed({2'b00, item_reg.x, 1'b0}) - $signed({2'b00, cfg.width})
             + DELTA_W'(1);
        dy = $signed({2'b00, item_reg.y, 1'b0}) - $signed({2'b00, cfg.height})
             + DELTA_W'(1);
        cdx_next = cfg.cosine * dx;
        sdy_next = cfg.sine * dy;
        sdx_next = cfg.sine * dx;
        cdy_next = cfg.cosine * dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_item_reg <= '0;
        else
            prod_item_reg <= item_reg;
    end

    always_ff @(posedge clk)
    begin
        cdx_reg <= cdx_next;
        sdy_reg <= sdy_next;
        sdx_reg <= sdx_next;
        cdy_reg <= cdy_next;
    end

    // Sums with the center term; (w-1)*2^14 + 2^14 folds to w*2^14
    always_comb
    begin
        sum_x = SUM_W'(cdx_reg) - SUM_W'(sdy_reg)
                + $signed({{(SUM_W-SIDE_W-FRAC_BITS){1'b0}}, cfg.width,
                           {FRAC_BITS{1'b0}}});
        sum_y = SUM_W'(sdx_reg) + SUM_W'(cdy_reg)
                + $signed({{(SUM_W-SIDE_W-FRAC_BITS){1'b0}}, cfg.height,
                           {FRAC_BITS{1'b0}}});
        // floor divide by 2^15
        rx_full = sum_x[SUM_W-1:FRAC_BITS+1];
        ry_full = sum_y[SUM_W-1:FRAC_BITS+1];
        rx_ok = !rx_full[COORD_W-1] &&
                (rx_full[COORD_W-2:0] < (COORD_W-1)'(cfg.width));
        ry_ok = !ry_full[COORD_W-1] &&
                (ry_full[COORD_W-2:0] < (COORD_W-1)'(cfg.height));

        mapped_next.item   = prod_item_reg;
        mapped_next.map_ok = rx_ok && ry_ok;
        mapped_next.rx     = rx_full[POS_W-1:0];
        mapped_next.ry     = ry_full[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mapped_reg <= '0;
        else
            mapped_reg <= mapped_next;
    end

    assign mapped = mapped_reg;

endmodule

`default_nettype wire

// ----- src/sprn_store.sv -----
// ----------------------------------------------------------------------------
// sprn_store
// Linear pixel address, sprite pixel memory and result color selection.
// ----------------------------------------------------------------------------
`default_nettype none

module sprn_store
    import sprn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  sprn_cfg_t  cfg,
    input  sprn_mapped_t mapped,
    output sprn_result_t result
);

    logic [POS_W-1:0]   sel_x, sel_y;
    logic [ADDR_W-1:0]  addr_next, addr_reg;
    logic               vld_reg, query_reg, inside_reg, map_ok_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               write_en, read_en;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic               res_vld_reg, res_inside_reg, res_map_ok_reg;

    // Loads address the source point, queries the mapped point
    always_comb
    begin
        sel_x     = mapped.item.query ? mapped.rx : mapped.item.x;
        sel_y     = mapped.item.query ? mapped.ry : mapped.item.y;
        addr_next = ADDR_W'(sel_y * cfg.width) + ADDR_W'(sel_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= mapped.item.vld;
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        query_reg  <= mapped.item.query;
        inside_reg <= mapped.item.in_sprite;
        map_ok_reg <= mapped.map_ok;
        color_reg  <= mapped.item.color;
    end

    // Memory access; loads and queries reach here in request order
    assign write_en = vld_reg && !query_reg && inside_reg;
    assign read_en  = vld_reg && query_reg && inside_reg && map_ok_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
            mem[addr_reg] <= color_reg;
    end

    always_ff @(posedge clk)
    begin
        if (read_en)
            rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else
            res_vld_reg <= vld_reg && query_reg;
    end

    always_ff @(posedge clk)
    begin
        res_inside_reg <= inside_reg;
        res_map_ok_reg <= map_ok_reg;
    end

    // Transparent when off the sprite on either side
    always_comb
    begin
        result.vld     = res_vld_reg;
        result.outside = !res_inside_reg;
        result.color   = (res_inside_reg && res_map_ok_reg) ? rd_data_reg
                                                            : COLOR_TRANSPARENT;
    end

endmodule

`default_nettype wire

// ----- src/sprn_outq.sv -----
// ----------------------------------------------------------------------------
// sprn_outq
// Result queue with request credits, so the pipe never has to stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sprn_outq
    import sprn_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_accept,
    input  wire logic          in_query,
    output logic               in_ready,
    input  sprn_result_t       result,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [COLOR_W-1:0] out_color,
    output logic               out_outside
);

    localparam int CNT_W = OQ_PTR_W + 1;

    logic [COLOR_W:0]  fifo [OQ_DEPTH];
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  credit_reg, credit_next;
    logic              pop;
    logic              take_query;

    // Every accepted query holds a slot until its result leaves; loads hold none
    assign in_ready   = (credit_reg < CNT_W'(OQ_DEPTH));
    assign out_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign pop        = out_valid && out_ready;
    assign take_query = in_accept && (in_query == ACT_QUERY);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + CNT_W'(result.vld);
        rd_ptr_next = rd_ptr_reg + CNT_W'(pop);
        credit_next = credit_reg + CNT_W'(take_query) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.vld)
            fifo[wr_ptr_reg[OQ_PTR_W-1:0]] <= {result.outside, result.color};
    end

    assign out_color   = fifo[rd_ptr_reg[OQ_PTR_W-1:0]][COLOR_W-1:0];
    assign out_outside = fifo[rd_ptr_reg[OQ_PTR_W-1:0]][COLOR_W];

endmodule

`default_nettype wire

// ----- src/sprite_nearest_rotate.sv -----
// Query path: input, product, mapped, address and read registers, then result queue.
// Throughput: one request per cycle, loads and queries alike; new requests
// are held back only while eight query results are pending, which a
// stalled sink alone can cause.
// Reset: configuration returns to sine 0, cosine 1.0, 64 x 64; pipeline and
// result queue empty. The pixel memory is not cleared and must be loaded.
// ----------------------------------------------------------------------------
// sprite_nearest_rotate
// Rotates a 4-bit sprite about its center by inverse nearest-neighbor lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_nearest_rotate
    import sprn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [TRIG_W-1:0] cfg_data,
    // Request stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,  // pos_x[5:0], pos_y[11:6], pixel_color[15:12]
    input  wire logic              s_tuser,  // action
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,  // rotated_color[3:0], zero[7:4]
    output logic                   m_tuser   // dest_outside
);

    sprn_cfg_t     cfg;
    sprn_mapped_t  mapped;
    sprn_result_t  result;
    logic          in_accept;
    logic [COLOR_W-1:0] out_color;

    assign in_accept = s_tvalid && s_tready;

    sprn_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sprn_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_query  (s_tuser),
        .in_x      (s_tdata[POS_W-1:0]),
        .in_y      (s_tdata[2*POS_W-1:POS_W]),
        .in_color  (s_tdata[2*POS_W+COLOR_W-1:2*POS_W]),
        .mapped    (mapped)
    );

    sprn_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .mapped (mapped),
        .result (result)
    );

    sprn_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .in_query    (s_tuser),
        .in_ready    (s_tready),
        .result      (result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_color   (out_color),
        .out_outside (m_tuser)
    );

    assign m_tdata = {4'b0000, out_color};

endmodule

`default_nettype wire

// ----- src/sprn_checker.sv -----
// ----------------------------------------------------------------------------
// sprn_checker
// Port-level checks for the sprite rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sprn_checker
    import sprn_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [7:0]        m_tdata,
    input wire logic              m_tuser
);

    // No result is shown in the cycle after a reset cycle
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An outside destination always answers transparent
    a_outside_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[COLOR_W-1:0] == COLOR_TRANSPARENT)
        else $error("outside destination not transparent");

    // Padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:COLOR_W] == '0)
        else $error("result padding not zero");

    // Configuration is never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind sprite_nearest_rotate sprn_checker u_sprn_checker (.*);

`default_nettype wire
